[rtl/ttsm_pkg.sv]
// Shared types, codes and constant tables for the throttle/temperature speed map.
package ttsm_pkg;

  localparam int THROTTLE_POINTS = 11;
  localparam int TEMP_POINTS     = 5;
  localparam int THR_IDX_W       = $clog2(THROTTLE_POINTS);
  localparam int TMP_IDX_W       = $clog2(TEMP_POINTS);
  localparam int REG_IDX_W       = 2;
  localparam int SHOWN_SLOTS     = 3;

  typedef enum logic [2:0] {
    OUTCOME_TABLE      = 3'd0,
    OUTCOME_THR_LIMIT  = 3'd1,
    OUTCOME_THR_OFFMAP = 3'd2,
    OUTCOME_TMP_OFFMAP = 3'd3,
    OUTCOME_SAFE       = 3'd4,
    OUTCOME_CLAMP      = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_THR   = 2'd1,
    FAULT_TMP   = 2'd2,
    FAULT_SPEED = 2'd3
  } fault_t;

  localparam logic [REG_IDX_W-1:0] REG_THROTTLE_LIMIT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_POINT_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SAFE_SPEED       = 2'd3;

  localparam logic [7:0] CODE_THR   = 8'hA1;
  localparam logic [7:0] CODE_TMP   = 8'hB2;
  localparam logic [7:0] CODE_SPEED = 8'hC3;
  localparam logic [7:0] CODE_EMPTY = 8'h00;

  localparam logic [7:0] RST_THROTTLE_LIMIT   = 8'd100;
  localparam logic [7:0] RST_TEMP_POINT_LIMIT = 8'd60;
  localparam logic [7:0] RST_SPEED_LIMIT      = 8'd255;
  localparam logic [7:0] RST_SAFE_SPEED       = 8'd50;

  localparam logic [7:0] THR_POINT [THROTTLE_POINTS] = '{
    8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 8'd100
  };

  localparam logic [7:0] TMP_POINT [TEMP_POINTS] = '{
    8'd40, 8'd50, 8'd70, 8'd90, 8'd110
  };

  localparam logic [7:0] SPEED_ROM [THROTTLE_POINTS][TEMP_POINTS] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd10,  8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd30,  8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd50,  8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd70,  8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd90,  8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd120, 8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd150, 8'd70,  8'd80,  8'd50,  8'd40 },
    '{8'd200, 8'd100, 8'd110, 8'd70,  8'd60 },
    '{8'd230, 8'd120, 8'd130, 8'd90,  8'd80 },
    '{8'd254, 8'd150, 8'd160, 8'd120, 8'd100}
  };

endpackage

[rtl/ttsm_sample_if.sv]
// Input channel: one throttle/temperature item per handshake.
interface ttsm_sample_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  throttle_percent;
  logic signed [10:0] temperature_c;

  modport source (output valid, throttle_percent, temperature_c, input ready);
  modport sink   (input valid, throttle_percent, temperature_c, output ready);
endinterface

[rtl/ttsm_result_if.sv]
// Output channel: speed, outcome, fault and fault log contents per item.
interface ttsm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] motor_speed;
  logic [2:0] outcome;
  logic [1:0] fault_raised;
  logic [7:0] log_slot_zero;
  logic [7:0] log_slot_one;
  logic [7:0] log_slot_two;

  modport source (output valid, motor_speed, outcome, fault_raised,
                  log_slot_zero, log_slot_one, log_slot_two, input ready);
  modport sink   (input valid, motor_speed, outcome, fault_raised,
                  log_slot_zero, log_slot_one, log_slot_two, output ready);
endinterface

[rtl/throttle_temp_speed_map_with_faults.sv]
// Top level: throttle/temperature speed map with limit checks and fault log.
// An item in the input register moves on to the result register once that register is empty or being read.
// Throughput: one item per cycle while the result is not stalled; the map, checks and log update sit in one stage.
// Reset (rst, synchronous): limits to defaults, fault log empty, both stages empty.
// A stalled result holds; the input register still takes an item while it is free.
module throttle_temp_speed_map_with_faults #(
  parameter int LOG_SLOTS = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  ttsm_sample_if.sink                    samp,
  ttsm_result_if.source                  res,
  input  logic                           wr_en,
  input  logic [ttsm_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [7:0]                     wr_data
);
  import ttsm_pkg::*;

  logic [7:0] throttle_limit;
  logic [7:0] temp_point_limit;
  logic [7:0] speed_limit;
  logic [7:0] safe_speed;

  logic               s_valid;
  logic signed [7:0]  s_thr;
  logic signed [10:0] s_tmp;
  logic               advance;

  logic [7:0] fault_log      [LOG_SLOTS];
  logic [7:0] fault_log_next [LOG_SLOTS];
  logic [7:0] shown          [SHOWN_SLOTS];

  logic                 thr_found;
  logic [THR_IDX_W-1:0] thr_idx;
  logic                 tmp_found;
  logic [TMP_IDX_W-1:0] tmp_idx;
  logic [7:0]           rom_speed;
  logic [7:0]           speed;
  outcome_t             outcome;
  fault_t               fault;
  logic [7:0]           code;
  logic                 present;
  logic [LOG_SLOTS-1:0] free_sel;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_limit   <= RST_THROTTLE_LIMIT;
      temp_point_limit <= RST_TEMP_POINT_LIMIT;
      speed_limit      <= RST_SPEED_LIMIT;
      safe_speed       <= RST_SAFE_SPEED;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THROTTLE_LIMIT:   throttle_limit   <= wr_data;
        REG_TEMP_POINT_LIMIT: temp_point_limit <= wr_data;
        REG_SPEED_LIMIT:      speed_limit      <= wr_data;
        REG_SAFE_SPEED:       safe_speed       <= wr_data;
      endcase
    end
  end

  assign advance    = s_valid && (!res.valid || res.ready);
  assign samp.ready = !s_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samp.ready) begin
      s_valid <= samp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samp.valid && samp.ready) begin
      s_thr <= samp.throttle_percent;
      s_tmp <= samp.temperature_c;
    end
  end

  // breakpoint searches, first point above the value
  always_comb begin
    thr_found = 1'b0;
    thr_idx   = '0;
    for (int i = THROTTLE_POINTS - 1; i >= 0; i--) begin
      if (s_thr < $signed({1'b0, THR_POINT[i]})) begin
        thr_found = 1'b1;
        thr_idx   = THR_IDX_W'(i);
      end
    end
    tmp_found = 1'b0;
    tmp_idx   = '0;
    for (int i = TEMP_POINTS - 1; i >= 0; i--) begin
      if (s_tmp < $signed({4'b0, TMP_POINT[i]})) begin
        tmp_found = 1'b1;
        tmp_idx   = TMP_IDX_W'(i);
      end
    end
  end

  assign rom_speed = SPEED_ROM[thr_idx][tmp_idx];

  always_comb begin
    speed   = rom_speed;
    outcome = OUTCOME_TABLE;
    fault   = FAULT_NONE;
    priority if (s_thr > $signed({1'b0, throttle_limit})) begin
      speed   = throttle_limit;
      outcome = OUTCOME_THR_LIMIT;
      fault   = FAULT_THR;
    end else if (!thr_found) begin
      speed   = '0;
      outcome = OUTCOME_THR_OFFMAP;
      fault   = FAULT_THR;
    end else if (!tmp_found) begin
      speed   = '0;
      outcome = OUTCOME_TMP_OFFMAP;
      fault   = FAULT_TMP;
    end else if (TMP_POINT[tmp_idx] > temp_point_limit) begin
      speed   = safe_speed;
      outcome = OUTCOME_SAFE;
      fault   = FAULT_TMP;
    end else if (rom_speed > speed_limit) begin
      speed   = speed_limit;
      outcome = OUTCOME_CLAMP;
      fault   = FAULT_SPEED;
    end else begin
      speed   = rom_speed;
    end
  end

  // fault log: skip if present, else highest empty slot, else drop
  always_comb begin
    unique case (fault)
      FAULT_NONE:  code = CODE_EMPTY;
      FAULT_THR:   code = CODE_THR;
      FAULT_TMP:   code = CODE_TMP;
      FAULT_SPEED: code = CODE_SPEED;
    endcase
    present  = 1'b0;
    free_sel = '0;
    for (int i = 0; i < LOG_SLOTS; i++) begin
      if (fault_log[i] == code) begin
        present = 1'b1;
      end
      if (fault_log[i] == CODE_EMPTY) begin
        free_sel    = '0;
        free_sel[i] = 1'b1;
      end
    end
    for (int i = 0; i < LOG_SLOTS; i++) begin
      fault_log_next[i] = fault_log[i];
      if (fault != FAULT_NONE && !present && free_sel[i]) begin
        fault_log_next[i] = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOG_SLOTS; i++) begin
        fault_log[i] <= CODE_EMPTY;
      end
    end else if (advance) begin
      fault_log <= fault_log_next;
    end
  end

  for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_shown
    if (g < LOG_SLOTS) begin : g_slot
      assign shown[g] = fault_log_next[g];
    end else begin : g_none
      assign shown[g] = CODE_EMPTY;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.motor_speed   <= speed;
      res.outcome       <= outcome;
      res.fault_raised  <= fault;
      res.log_slot_zero <= shown[0];
      res.log_slot_one  <= shown[1];
      res.log_slot_two  <= shown[2];
    end
  end

`ifndef SYNTHESIS
  for (genvar g = 0; g < LOG_SLOTS; g++) begin : g_log_chk
    a_slot_sticky: assert property (@(posedge clk) disable iff (rst)
      (fault_log[g] != CODE_EMPTY) |=> (fault_log[g] == $past(fault_log[g])))
      else $error("filled fault log slot changed");

    a_log_advance_only: assert property (@(posedge clk) disable iff (rst)
      !$past(advance) && !$past(rst) |-> (fault_log[g] == $past(fault_log[g])))
      else $error("fault log changed without an item");
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !advance) |=> s_valid)
    else $error("input register lost an item under stall");

  a_table_no_fault: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.outcome == OUTCOME_TABLE) |-> (res.fault_raised == FAULT_NONE))
    else $error("table outcome with a fault raised");

  a_clamp_speed: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.outcome == OUTCOME_CLAMP) |-> (res.motor_speed == speed_limit))
    else $error("clamped speed differs from speed limit");
`endif

endmodule
